>>> sv/rc4_keystream_generator_top_assert.svh
// Assertion macros used by the keystream generator checker.
`ifndef RC4_KEYSTREAM_GENERATOR_TOP_ASSERT_SVH
`define RC4_KEYSTREAM_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while rst is high.
`define RC4KS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst is high.
`define RC4KS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/rc4ks_pkg.sv
// Shared field widths, mode codes and word size reset of the keystream generator.
`timescale 1ns / 1ps
package rc4ks_pkg;

  // Field widths of one input word and one result word
  localparam int MODE_W      = 2;
  localparam int KEY_IDX_W   = 8;
  localparam int KEY_VAL_W   = 8;
  localparam int KEY_LEN_W   = 9;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_W       = 4;

  typedef logic [MODE_W-1:0] mode_t;

  // Input word kinds, carried on tuser
  localparam mode_t MODE_LOAD  = 2'd0;
  localparam mode_t MODE_SCHED = 2'd1;
  localparam mode_t MODE_GEN   = 2'd2;

  localparam logic [CFG_W-1:0] WORD_BITS_RESET = 4'd8;

endpackage

>>> sv/rc4_keystream_generator_top.sv
`timescale 1ns / 1ps
// RC4-style keystream generator with a run-time word size, one two-port S-box.
//
//  channel      dir  tdata (low bit up)                          tuser
//  s_axis       in   key_index[7:0] key_value[15:8] key_len[24:16] mode[1:0]
//  m_axis       out  keystream_word[7:0]                           -
//  word_bits    in   write enable plus 4-bit data, no read-back    -
//
// Load key word: written to the key store while the sequencer stays idle.
// Generate: steps G0 to G3 (S-box reads in G0, G1, G2, writes in G2, G3), result
// registered in G3, then idle; a stalled result holds the sequencer in its last step.
// Key schedule: a fill sweep of the S-box, then one swap per entry with four S-box
// accesses (K0 to K3). s_axis_tready is high only while idle.
// Reset clears the indices and sets the word size to 8; the S-box and key store
// are not cleared and must be filled by a schedule and key loads before use.
module rc4_keystream_generator_top #(
  parameter int MAX_WORD_BITS = 8,
  parameter int KEY_DEPTH     = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // key_index[7:0], key_value[15:8], key_len[24:16], zero fill above
  input  logic [rc4ks_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // mode[1:0]
  input  logic [rc4ks_pkg::MODE_W-1:0]       s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // keystream_word[7:0]
  output logic [rc4ks_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                               word_bits_wr_en,
  input  logic [rc4ks_pkg::CFG_W-1:0]        word_bits_wr_data
);
  import rc4ks_pkg::*;

  localparam int SW     = MAX_WORD_BITS;
  localparam int SDEPTH = 1 << SW;
  localparam int KW     = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

  // Sequencer codes
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_INIT = 4'd1;
  localparam logic [3:0] ST_K0   = 4'd2;
  localparam logic [3:0] ST_K1   = 4'd3;
  localparam logic [3:0] ST_K2   = 4'd4;
  localparam logic [3:0] ST_K3   = 4'd5;
  localparam logic [3:0] ST_G0   = 4'd6;
  localparam logic [3:0] ST_G1   = 4'd7;
  localparam logic [3:0] ST_G2   = 4'd8;
  localparam logic [3:0] ST_G3   = 4'd9;

  logic [3:0]           state;
  logic [CFG_W-1:0]     word_bits;
  logic [SW-1:0]        ii;
  logic [SW-1:0]        jj;
  logic [SW-1:0]        idx;
  logic [KW-1:0]        kidx;
  logic [KW-1:0]        klast;
  logic [SW-1:0]        si;
  logic [SW-1:0]        sj;
  logic [SW-1:0]        tt;
  logic [OUT_TDATA_W-1:0] out_word;
  logic                 out_valid;

  // S-box and key store
  logic [SW-1:0]        sbox [SDEPTH];
  logic [KEY_VAL_W-1:0] key_store [KEY_DEPTH];
  logic [SW-1:0]        s_rdata;
  logic [KEY_VAL_W-1:0] k_rdata;
  logic                 s_we;
  logic                 s_re;
  logic [SW-1:0]        s_waddr;
  logic [SW-1:0]        s_wdata;
  logic [SW-1:0]        s_raddr;

  // Input unpacking
  mode_t                in_mode;
  logic [KEY_IDX_W-1:0] in_key_index;
  logic [KEY_VAL_W-1:0] in_key_value;
  logic [KEY_LEN_W-1:0] in_key_len;
  logic [KEY_LEN_W-1:0] klen_c;
  logic                 in_acc;
  logic                 out_free;

  // Working values
  logic [CFG_W-1:0]     eff;
  logic [SW-1:0]        mask;
  logic [SW-1:0]        gi_new;
  logic [SW-1:0]        gj_new;
  logic [SW-1:0]        kj_new;
  logic [SW-1:0]        t_new;
  logic [SW-1:0]        gen_res;

  assign in_mode      = mode_t'(s_axis_tuser);
  assign in_key_index = s_axis_tdata[KEY_IDX_W-1:0];
  assign in_key_value = s_axis_tdata[KEY_IDX_W +: KEY_VAL_W];
  assign in_key_len   = s_axis_tdata[KEY_IDX_W+KEY_VAL_W +: KEY_LEN_W];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_word;

  // Word size clamped to 1..MAX_WORD_BITS, and its element mask
  always_comb begin
    if (word_bits == '0) begin
      eff = CFG_W'(1);
    end else if (word_bits > CFG_W'(MAX_WORD_BITS)) begin
      eff = CFG_W'(MAX_WORD_BITS);
    end else begin
      eff = word_bits;
    end
    mask = ~({SW{1'b1}} << eff);
  end

  // Key length clamped to 1..KEY_DEPTH
  always_comb begin
    if (in_key_len == '0) begin
      klen_c = KEY_LEN_W'(1);
    end else if (in_key_len > KEY_LEN_W'(KEY_DEPTH)) begin
      klen_c = KEY_LEN_W'(KEY_DEPTH);
    end else begin
      klen_c = in_key_len;
    end
  end

  // Index arithmetic, all modulo 2^eff
  assign gi_new = (ii + SW'(1)) & mask;
  assign gj_new = (jj + (s_rdata & mask)) & mask;
  assign kj_new = (jj + s_rdata + k_rdata[SW-1:0]) & mask;
  assign t_new  = ((si & mask) + (s_rdata & mask)) & mask;

  // Post-swap S[t]: forward the entries still in flight on the port
  always_comb begin
    if (tt == jj) begin
      gen_res = si;
    end else if (tt == ii) begin
      gen_res = sj;
    end else begin
      gen_res = s_rdata;
    end
  end

  // S-box port control
  always_comb begin
    s_we    = 1'b0;
    s_re    = 1'b0;
    s_waddr = idx;
    s_wdata = idx;
    s_raddr = idx;
    case (state)
      ST_INIT: begin
        s_we = 1'b1;
      end
      ST_K0: begin
        s_re = 1'b1;
      end
      ST_K1: begin
        s_re    = 1'b1;
        s_raddr = kj_new;
      end
      ST_K2: begin
        s_we    = 1'b1;
        s_wdata = s_rdata;
      end
      ST_K3: begin
        s_we    = 1'b1;
        s_waddr = jj;
        s_wdata = si;
      end
      ST_G0: begin
        s_re    = 1'b1;
        s_raddr = gi_new;
      end
      ST_G1: begin
        s_re    = 1'b1;
        s_raddr = gj_new;
      end
      ST_G2: begin
        s_we    = 1'b1;
        s_waddr = ii;
        s_wdata = s_rdata;
        s_re    = 1'b1;
        s_raddr = t_new;
      end
      ST_G3: begin
        s_we    = 1'b1;
        s_waddr = jj;
        s_wdata = si;
      end
      default: begin
        s_we = 1'b0;
      end
    endcase
  end

  // S-box memory, registered read
  always_ff @(posedge clk) begin
    if (s_we) begin
      sbox[s_waddr] <= s_wdata;
    end
    if (s_re) begin
      s_rdata <= sbox[s_raddr];
    end
  end

  // Key store memory, written on a load word, read during the schedule
  always_ff @(posedge clk) begin
    if (in_acc && in_mode == MODE_LOAD &&
        {1'b0, in_key_index} < KEY_LEN_W'(KEY_DEPTH)) begin
      key_store[KW'(in_key_index)] <= in_key_value;
    end
    if (state == ST_K0) begin
      k_rdata <= key_store[kidx];
    end
  end

  // Word size register
  always_ff @(posedge clk) begin
    if (rst) begin
      word_bits <= WORD_BITS_RESET;
    end else if (word_bits_wr_en) begin
      word_bits <= word_bits_wr_data;
    end
  end

  // Result valid: set when the last generate step lands, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_G3 && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer and index registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ii    <= '0;
      jj    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_mode == MODE_SCHED) begin
              idx   <= '0;
              jj    <= '0;
              klast <= KW'(klen_c - KEY_LEN_W'(1));
              state <= ST_INIT;
            end else if (in_mode == MODE_GEN) begin
              state <= ST_G0;
            end
          end
        end
        // fill S[a] = a
        ST_INIT: begin
          if (idx == mask) begin
            idx   <= '0;
            kidx  <= '0;
            state <= ST_K0;
          end else begin
            idx <= idx + SW'(1);
          end
        end
        ST_K0: begin
          state <= ST_K1;
        end
        ST_K1: begin
          si    <= s_rdata;
          jj    <= kj_new;
          state <= ST_K2;
        end
        ST_K2: begin
          state <= ST_K3;
        end
        // second half of the swap, then next i
        ST_K3: begin
          if (idx == mask) begin
            ii    <= '0;
            jj    <= '0;
            state <= ST_IDLE;
          end else begin
            idx   <= idx + SW'(1);
            kidx  <= (kidx == klast) ? '0 : kidx + KW'(1);
            state <= ST_K0;
          end
        end
        ST_G0: begin
          ii    <= gi_new;
          state <= ST_G1;
        end
        ST_G1: begin
          si    <= s_rdata;
          jj    <= gj_new;
          state <= ST_G2;
        end
        ST_G2: begin
          sj    <= s_rdata;
          tt    <= t_new;
          state <= ST_G3;
        end
        // hold here until the output register is free
        ST_G3: begin
          if (out_free) begin
            out_word <= OUT_TDATA_W'(gen_res & mask);
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/rc4ks_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the keystream generator, bound to the top level.
`include "rc4_keystream_generator_top_assert.svh"

module rc4ks_checker #(
  parameter int MAX_WORD_BITS = 8
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic [rc4ks_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input logic [rc4ks_pkg::MODE_W-1:0]       s_axis_tuser,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [rc4ks_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                               word_bits_wr_en,
  input logic [rc4ks_pkg::CFG_W-1:0]        word_bits_wr_data
);
  import rc4ks_pkg::*;

  logic [CFG_W-1:0] wb;
  logic [CFG_W-1:0] eff;
  logic [1:0]       gen_cnt;
  logic             in_acc;
  logic             out_acc;
  logic             gen_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign gen_acc = in_acc && mode_t'(s_axis_tuser) == MODE_GEN;

  // Mirror of the word size register
  always_ff @(posedge clk) begin
    if (rst) begin
      wb <= WORD_BITS_RESET;
    end else if (word_bits_wr_en) begin
      wb <= word_bits_wr_data;
    end
  end

  always_comb begin
    if (wb == '0) begin
      eff = CFG_W'(1);
    end else if (wb > CFG_W'(MAX_WORD_BITS)) begin
      eff = CFG_W'(MAX_WORD_BITS);
    end else begin
      eff = wb;
    end
  end

  // Generate words accepted and not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_cnt <= '0;
    end else begin
      gen_cnt <= gen_cnt + 2'(gen_acc) - 2'(out_acc);
    end
  end

  `RC4KS_ASSERT_NOW(a_word_in_range, m_axis_tvalid, (m_axis_tdata >> eff) == '0, "keystream word wider than word size")
  `RC4KS_ASSERT_NOW(a_out_has_cause, $rose(m_axis_tvalid), gen_cnt != 2'd0, "result without a generate word")
  `RC4KS_ASSERT_NEXT(a_gen_busy, gen_acc, !s_axis_tready, "ready stayed high after a generate word")
  `RC4KS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind rc4_keystream_generator_top rc4ks_checker #(
  .MAX_WORD_BITS(MAX_WORD_BITS)
) u_rc4ks_checker (.*);

>>> test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the RC4-style keystream generator: directed table, then random.
module tb;
  import rc4ks_pkg::*;

  localparam int      SETTLE_CYCLES = 1400;       // longer than a full 256-entry key schedule
  localparam longint  CYCLE_LIMIT   = 10_000_000;
  localparam int      RAND_PHASES   = 8;
  localparam int      PHASE_ITEMS   = 203;
  localparam mode_t   MODE_NONE     = 2'd3;       // unused code, block ignores it

  // DUT ports; the driven inputs are known from time zero
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [MODE_W-1:0]      s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   word_bits_wr_en = 1'b0;
  logic [CFG_W-1:0]       word_bits_wr_data = '0;

  rc4_keystream_generator_top i_dut (
    .clk               (clk),
    .rst               (rst),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tuser      (s_axis_tuser),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .word_bits_wr_en   (word_bits_wr_en),
    .word_bits_wr_data (word_bits_wr_data)
  );

  always #5 clk = ~clk;

  // Keystream predictor state
  logic [7:0]       sbox_p [256];
  logic [7:0]       key_p  [256];
  logic [7:0]       idx_i_p = '0;
  logic [7:0]       idx_j_p = '0;
  logic [CFG_W-1:0] word_bits_p = WORD_BITS_RESET;

  // What has been written so far, so that no undefined entry is ever read
  bit               key_loaded [256];
  int unsigned      sbox_span = 0;

  logic [7:0]       keystream_due [$];
  logic [7:0]       due_word;
  int               errors = 0;
  longint           cycle_count = 0;
  int unsigned      send_idle = 0;
  int unsigned      recv_stall = 0;

  typedef struct {
    bit               is_cfg;
    logic [CFG_W-1:0] cfg;
    mode_t            mode;
    logic [7:0]       kidx;
    logic [7:0]       kval;
    logic [8:0]       klen;
    bit               has_exp;
    logic [7:0]       exp_word;
  } stim_row_t;

  stim_row_t stim_rows [$];

  function automatic int unsigned eff_word_bits(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > 8) return 8;
    return v;
  endfunction

  function automatic int unsigned eff_key_len(logic [8:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  function automatic void swap_sbox(int unsigned a, int unsigned b);
    logic [7:0] t;
    t = sbox_p[a];
    sbox_p[a] = sbox_p[b];
    sbox_p[b] = t;
  endfunction

  // One input word through the predictor; returns 1 when a keystream word results
  function automatic bit keystream_step(mode_t m, logic [7:0] kidx, logic [7:0] kval,
                                        logic [8:0] klen, output logic [7:0] word);
    int unsigned size, mask, len, i, j, k, t;
    size = 1 << eff_word_bits(word_bits_p);
    mask = size - 1;
    word = '0;
    case (m)
      MODE_LOAD: begin
        key_p[kidx] = kval;
        return 0;
      end
      MODE_SCHED: begin
        len = eff_key_len(klen);
        for (k = 0; k < size; k++) sbox_p[k] = k[7:0];
        j = 0;
        for (k = 0; k < size; k++) begin
          j = (j + sbox_p[k] + key_p[k % len]) & mask;
          swap_sbox(k, j);
        end
        idx_i_p = '0;
        idx_j_p = '0;
        return 0;
      end
      MODE_GEN: begin
        i = (idx_i_p + 1) & mask;
        j = (idx_j_p + (sbox_p[i] & mask)) & mask;
        swap_sbox(i, j);
        t = ((sbox_p[i] & mask) + (sbox_p[j] & mask)) & mask;
        idx_i_p = i[7:0];
        idx_j_p = j[7:0];
        word = sbox_p[t] & mask[7:0];
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic void add_cfg(logic [CFG_W-1:0] v);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.cfg = v;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_item(mode_t m, logic [7:0] kidx, logic [7:0] kval,
                                   logic [8:0] klen, bit has_exp, logic [7:0] exp_word);
    stim_row_t r;
    r = '{default: '0};
    r.mode = m;
    r.kidx = kidx;
    r.kval = kval;
    r.klen = klen;
    r.has_exp = has_exp;
    r.exp_word = exp_word;
    stim_rows.push_back(r);
  endfunction

  // Present one word, wait for the handshake, then predict
  task automatic send_word(mode_t m, logic [7:0] kidx, logic [7:0] kval, logic [8:0] klen,
                           bit has_exp, logic [7:0] exp_word);
    logic [7:0]  word;
    int unsigned size;
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, klen, kval, kidx};
    s_axis_tuser  <= m;
    do @(posedge clk); while (!s_axis_tready);
    size = 1 << eff_word_bits(word_bits_p);
    if (m == MODE_LOAD) key_loaded[kidx] = 1'b1;
    if (m == MODE_SCHED && size > sbox_span) sbox_span = size;
    if (keystream_step(m, kidx, kval, klen, word))
      keystream_due.push_back(has_exp ? exp_word : word);
  endtask

  // Drain the results, let a schedule in flight finish, then write the word size
  task automatic write_word_bits(logic [CFG_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (keystream_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    word_bits_wr_en   <= 1'b1;
    word_bits_wr_data <= v;
    @(posedge clk);
    word_bits_wr_en <= 1'b0;
    word_bits_p = v;
  endtask

  // Schedule with a random length, loading any key word it would read first
  task automatic random_schedule();
    logic [8:0]  klen;
    int unsigned size, used, k;
    size = 1 << eff_word_bits(word_bits_p);
    if ($urandom_range(99) < 30) klen = $urandom_range(511);
    else                         klen = $urandom_range(size, 1);
    used = eff_key_len(klen);
    if (used > size) used = size;
    for (k = 0; k < used; k++)
      if (!key_loaded[k]) send_word(MODE_LOAD, k[7:0], $urandom_range(255), '0, 0, '0);
    send_word(MODE_SCHED, $urandom_range(255), $urandom_range(255), klen, 0, '0);
  endtask

  task automatic random_phase(int n);
    int          r;
    int unsigned size;
    for (int c = 0; c < n; c++) begin
      r = $urandom_range(99);
      size = 1 << eff_word_bits(word_bits_p);
      if (r < 2)
        send_word(MODE_NONE, $urandom_range(255), $urandom_range(255), $urandom_range(511),
                  0, '0);
      else if (r < 17)
        send_word(MODE_LOAD, $urandom_range(255), $urandom_range(255), $urandom_range(511),
                  0, '0);
      else if (r < 24 || size > sbox_span)
        random_schedule();
      else
        send_word(MODE_GEN, $urandom_range(255), $urandom_range(255), $urandom_range(511),
                  0, '0);
    end
  endtask

  // Result side: check against the oldest expectation, then pick the next stall
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (keystream_due.size() == 0) begin
        errors++;
        $display("%0t: keystream word with none due: expected none, actual %0h",
                 $time, m_axis_tdata);
      end else begin
        due_word = keystream_due.pop_front();
        if (m_axis_tdata !== due_word) begin
          errors++;
          $display("%0t: keystream_word mismatch: expected %0h, actual %0h",
                   $time, due_word, m_axis_tdata);
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [CFG_W-1:0] cfg_list [RAND_PHASES];
    cfg_list = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'd6, 4'd2, 4'd8};
    cfg_list[6] = $urandom_range(15);

    // Directed table: size-two S-box first, where the first words can be worked by hand
    add_cfg(4'd1);
    add_item(MODE_LOAD,  8'd0,   8'd0,   9'd0,   0, '0);
    add_item(MODE_LOAD,  8'd1,   8'd0,   9'd0,   0, '0);
    add_item(MODE_SCHED, 8'd0,   8'd0,   9'd0,   0, '0);   // zero length acts as one
    add_item(MODE_GEN,   8'd0,   8'd0,   9'd0,   1, 8'd0);
    add_item(MODE_GEN,   8'd0,   8'd0,   9'd0,   1, 8'd0);
    add_item(MODE_GEN,   8'd0,   8'd0,   9'd0,   1, 8'd1);
    add_item(MODE_GEN,   8'd0,   8'd0,   9'd0,   1, 8'd1);
    add_item(MODE_NONE,  8'hff,  8'hff,  9'h1ff, 0, '0);   // unused mode, no word
    add_item(MODE_LOAD,  8'd255, 8'd255, 9'd0,   0, '0);
    add_item(MODE_LOAD,  8'd1,   8'd255, 9'd0,   0, '0);
    add_item(MODE_SCHED, 8'd0,   8'd0,   9'd511, 0, '0);   // over-long key clips to 256
    add_item(MODE_GEN,   8'd0,   8'd0,   9'd0,   0, '0);
    add_item(MODE_GEN,   8'd0,   8'd0,   9'd0,   0, '0);
    add_item(MODE_SCHED, 8'd0,   8'd0,   9'd256, 0, '0);
    add_item(MODE_GEN,   8'd0,   8'd0,   9'd0,   0, '0);
    add_cfg(4'd0);                                          // zero word size acts as one
    add_item(MODE_GEN,   8'd0,   8'd0,   9'd0,   0, '0);
    add_item(MODE_GEN,   8'd0,   8'd0,   9'd0,   0, '0);
    add_cfg(4'd15);                                         // clips to eight bits
    add_item(MODE_SCHED, 8'd0,   8'd0,   9'd1,   0, '0);
    add_item(MODE_GEN,   8'd0,   8'd0,   9'd0,   0, '0);
    add_item(MODE_GEN,   8'd0,   8'd0,   9'd0,   0, '0);
    add_cfg(4'd8);
    add_item(MODE_SCHED, 8'd0,   8'd0,   9'd2,   0, '0);
    add_item(MODE_GEN,   8'd0,   8'd0,   9'd0,   0, '0);
    add_item(MODE_GEN,   8'd0,   8'd0,   9'd0,   0, '0);
    add_cfg(4'd4);                                          // shrink after schedule, masked use
    add_item(MODE_GEN,   8'd0,   8'd0,   9'd0,   0, '0);
    add_item(MODE_NONE,  8'd0,   8'd0,   9'd0,   0, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[n]) begin
      if (stim_rows[n].is_cfg)
        write_word_bits(stim_rows[n].cfg);
      else
        send_word(stim_rows[n].mode, stim_rows[n].kidx, stim_rows[n].kval, stim_rows[n].klen,
                  stim_rows[n].has_exp, stim_rows[n].exp_word);
    end

    // Random phases, rotating through the idling patterns
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_word_bits(cfg_list[p]);
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 78; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 78; end
        default: begin send_idle = 27; recv_stall = 27; end
      endcase
      random_phase(PHASE_ITEMS);
    end

    s_axis_tvalid <= 1'b0;
    while (keystream_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/rc4ks_pkg.sv
sv/rc4_keystream_generator_top.sv
sv/rc4ks_checker.sv
test/tb.sv
